// ===== rtl/ptw_pkg.sv =====
// Shared constants, types and helpers for the page table walk unit.
`timescale 1ns / 1ps
package ptw_pkg;

	localparam int OFFSET_BITS = 4;
	localparam int LEVELS      = 3;
	localparam int VADDR_BITS  = 16;
	localparam int FRAME_COUNT = 64;
	localparam int DATA_BITS   = 32;

	localparam int PAGE_WORDS  = 1 << OFFSET_BITS;
	localparam int BPT         = (VADDR_BITS - OFFSET_BITS) / LEVELS;
	localparam int PAGE_BITS   = VADDR_BITS - OFFSET_BITS;
	localparam int PAGE_COUNT  = 1 << PAGE_BITS;
	localparam int DIST_BITS   = PAGE_BITS + 1;
	localparam int FRAME_BITS  = $clog2(FRAME_COUNT);
	localparam int PHYS_AW     = FRAME_BITS + OFFSET_BITS;
	localparam int PHYS_WORDS  = FRAME_COUNT * PAGE_WORDS;
	localparam int SWAP_AW     = VADDR_BITS;
	localparam int SWAP_WORDS  = 1 << SWAP_AW;
	localparam int DEP_BITS    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	typedef logic [FRAME_BITS-1:0] frame_t;
	typedef logic [OFFSET_BITS-1:0] off_t;
	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [PHYS_AW-1:0] phys_addr_t;
	typedef logic [SWAP_AW-1:0] swap_addr_t;
	typedef logic [DEP_BITS-1:0] dep_t;
	typedef logic [DATA_BITS-1:0] word_t;

	localparam dep_t DEP_MAX = dep_t'(LEVELS - 1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_WALK_RD, S_WALK_EV, S_SCAN_INIT, S_SCAN_RD, S_SCAN_EV,
		S_SCAN_POP, S_PICK, S_UNLINK, S_CP_RD, S_CP_WR, S_CLR_FRAME, S_LINK,
		S_RS_RD, S_RS_WR, S_ACC, S_OUT_OK, S_OUT_FAIL
	} ctl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_WALK_RD, OP_WALK_EV, OP_SCAN_INIT, OP_SCAN_RD,
		OP_SCAN_EV, OP_SCAN_POP, OP_PICK, OP_UNLINK, OP_CP_RD, OP_CP_WR,
		OP_CLR_FRAME, OP_LINK, OP_RS_RD, OP_RS_WR, OP_ACC, OP_OUT_OK, OP_OUT_FAIL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic walk_zero;
		logic layer_last;
		logic ev_push;
		logic ev_last;
		logic pop_root;
		logic pop_up_last;
		logic empty_valid;
		logic max_small;
		logic victim_valid;
		logic cnt_last;
		logic out_free;
	} dp_stat_t;

	function automatic off_t lvl_idx(page_t page, dep_t layer);
		page_t sh;
		sh = page >> (BPT * (LEVELS - 1 - int'(layer)));
		return off_t'(sh[BPT-1:0]);
	endfunction

endpackage

// ===== rtl/page_table_walk_fault_handler_unit.sv =====
// Top level: virtual word access through a three-level page table with swap-backed eviction.
// After reset the unit sweeps its 65536-word swap store to zero (and clears
// frame 0 of the physical store), one word per cycle, so in_ready stays low
// until the sweep is done. An access that hits reads one table entry per level
// and then the data word. A fault runs, for each missing level, a depth-first
// scan of the table tree, then fills a frame: an empty table frame is relinked
// as it is, a fresh frame is cleared, and an evicted page is first saved to
// swap and then cleared. Finally it restores the 16-word data page from swap;
// if no frame can be found the result reports a failure. Every word read from
// the physical store is registered first and used from that register. One item
// is in flight at a time; the result register lets the next beat enter while a
// result is still waiting to be taken.
`timescale 1ns / 1ps
module page_table_walk_fault_handler_unit import ptw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] virtual_address,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [31:0] read_data,
	output logic        page_fault,
	output logic [1:0]  pages_evicted
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	ptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ptw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.virtual_address (virtual_address),
		.write_value     (write_value),
		.cmd             (cmd),
		.st              (st),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.ok              (ok),
		.read_data       (read_data),
		.page_fault      (page_fault),
		.pages_evicted   (pages_evicted)
	);

endmodule

// ===== rtl/ptw_dp.sv =====
// Datapath: physical and swap stores, walk registers, scan stack and result register.
`timescale 1ns / 1ps
module ptw_dp import ptw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op,
	input  logic [15:0] virtual_address,
	input  logic [31:0] write_value,
	input  dp_cmd_t     cmd,
	output dp_stat_t    st,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        ok,
	output logic [31:0] read_data,
	output logic        page_fault,
	output logic [1:0]  pages_evicted
);

	word_t phys_mem [PHYS_WORDS];
	word_t swap_mem [SWAP_WORDS];
	word_t phys_rd_q, swap_rd_q;

	logic       op_q;
	logic [VADDR_BITS-1:0] va_q;
	word_t      wv_q;
	frame_t     frame_q, last_q, next_q;
	dep_t       layer_q;
	logic       fault_q;
	logic [1:0] evict_q;
	off_t       cnt_q;
	swap_addr_t clr_q;

	frame_t     fr_q  [LEVELS];
	off_t       idx_q [LEVELS];
	logic       az_q  [LEVELS];
	phys_addr_t par_q [LEVELS];
	dep_t       dep_q;

	frame_t     max_q;
	logic       empty_v_q;
	frame_t     empty_fr_q;
	phys_addr_t empty_par_q;
	logic       vic_v_q;
	frame_t     vic_fr_q;
	phys_addr_t vic_par_q;
	page_t      vic_page_q;
	dist_t      best_q;
	phys_addr_t unlink_q;

	logic       out_valid_q, ok_q, pf_q;
	logic [31:0] rdata_q;
	logic [1:0] ev_q;

	page_t      page;
	off_t       woff;
	off_t       lvl;
	phys_addr_t cur_addr;
	logic       nz;
	frame_t     vf;
	page_t      path, d;
	dist_t      d2, m;
	dep_t       dep_up;
	logic       out_free;

	logic       pw_en, pr_en, sw_en, sr_en;
	phys_addr_t pw_addr, pr_addr;
	word_t      pw_data, sw_data;
	swap_addr_t sw_addr, sr_addr;

	always_comb begin
		page     = va_q[VADDR_BITS-1:OFFSET_BITS];
		woff     = va_q[OFFSET_BITS-1:0];
		lvl      = lvl_idx(page, layer_q);
		cur_addr = {fr_q[dep_q], idx_q[dep_q]};
		nz       = |phys_rd_q;
		vf       = phys_rd_q[FRAME_BITS-1:0];
		dep_up   = dep_q - dep_t'(1);
		path     = '0;
		for (int l = 0; l < LEVELS; l++) begin
			path = (path << BPT) | page_t'(idx_q[l]);
		end
		d        = (page > path) ? page - path : path - page;
		d2       = dist_t'(PAGE_COUNT) - {1'b0, d};
		m        = ({1'b0, d} > d2) ? d2 : {1'b0, d};
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		st.clr_last     = &clr_q;
		st.walk_zero    = !nz;
		st.layer_last   = layer_q == DEP_MAX;
		st.ev_push      = nz && (dep_q != DEP_MAX);
		st.ev_last      = &idx_q[dep_q];
		st.pop_root     = dep_q == '0;
		st.pop_up_last  = &idx_q[dep_up];
		st.empty_valid  = empty_v_q;
		st.max_small    = max_q < frame_t'(FRAME_COUNT - 1);
		st.victim_valid = vic_v_q;
		st.cnt_last     = &cnt_q;
		st.out_free     = out_free;
	end

	always_comb begin
		pw_en   = 1'b0;
		pw_addr = '0;
		pw_data = '0;
		pr_en   = 1'b0;
		pr_addr = '0;
		sw_en   = 1'b0;
		sw_addr = clr_q;
		sw_data = '0;
		sr_en   = 1'b0;
		sr_addr = {page, cnt_q};
		unique case (cmd.op)
			OP_CLR: begin
				pw_en   = (clr_q >> OFFSET_BITS) == '0;
				pw_addr = clr_q[PHYS_AW-1:0];
				sw_en   = 1'b1;
			end
			OP_WALK_RD: begin
				pr_en   = 1'b1;
				pr_addr = {frame_q, lvl};
			end
			OP_SCAN_RD: begin
				pr_en   = 1'b1;
				pr_addr = cur_addr;
			end
			OP_UNLINK: begin
				pw_en   = 1'b1;
				pw_addr = unlink_q;
			end
			OP_CP_RD: begin
				pr_en   = 1'b1;
				pr_addr = {next_q, cnt_q};
			end
			OP_CP_WR: begin
				sw_en   = 1'b1;
				sw_addr = {vic_page_q, cnt_q};
				sw_data = phys_rd_q;
			end
			OP_CLR_FRAME: begin
				pw_en   = 1'b1;
				pw_addr = {next_q, cnt_q};
			end
			OP_LINK: begin
				pw_en   = 1'b1;
				pw_addr = {last_q, lvl};
				pw_data = word_t'(next_q);
			end
			OP_RS_RD: sr_en = 1'b1;
			OP_RS_WR: begin
				pw_en   = 1'b1;
				pw_addr = {last_q, cnt_q};
				pw_data = swap_rd_q;
			end
			OP_ACC: begin
				pw_en   = op_q;
				pr_en   = !op_q;
				pw_addr = {frame_q, woff};
				pr_addr = {frame_q, woff};
				pw_data = wv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pw_en) phys_mem[pw_addr] <= pw_data;
		if (pr_en) phys_rd_q <= phys_mem[pr_addr];
	end

	always_ff @(posedge clk) begin
		if (sw_en) swap_mem[sw_addr] <= sw_data;
		if (sr_en) swap_rd_q <= swap_mem[sr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= 1'b0;
			va_q        <= '0;
			wv_q        <= '0;
			frame_q     <= '0;
			last_q      <= '0;
			next_q      <= '0;
			layer_q     <= '0;
			fault_q     <= 1'b0;
			evict_q     <= '0;
			cnt_q       <= '0;
			clr_q       <= '0;
			dep_q       <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				fr_q[l]  <= '0;
				idx_q[l] <= '0;
				az_q[l]  <= 1'b0;
				par_q[l] <= '0;
			end
			max_q       <= '0;
			empty_v_q   <= 1'b0;
			empty_fr_q  <= '0;
			empty_par_q <= '0;
			vic_v_q     <= 1'b0;
			vic_fr_q    <= '0;
			vic_par_q   <= '0;
			vic_page_q  <= '0;
			best_q      <= '0;
			unlink_q    <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			pf_q        <= 1'b0;
			rdata_q     <= '0;
			ev_q        <= '0;
		end else begin
			if (cmd.op == OP_OUT_OK || cmd.op == OP_OUT_FAIL) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_CLR: clr_q <= clr_q + swap_addr_t'(1);
				OP_LOAD: begin
					op_q    <= op;
					va_q    <= virtual_address[VADDR_BITS-1:0];
					wv_q    <= write_value;
					frame_q <= '0;
					layer_q <= '0;
					fault_q <= 1'b0;
					evict_q <= '0;
				end
				OP_WALK_EV: begin
					last_q  <= frame_q;
					frame_q <= vf;
					if (!nz) fault_q <= 1'b1;
					else if (layer_q != DEP_MAX) layer_q <= layer_q + dep_t'(1);
				end
				OP_SCAN_INIT: begin
					dep_q      <= '0;
					fr_q[0]    <= '0;
					idx_q[0]   <= '0;
					az_q[0]    <= 1'b1;
					par_q[0]   <= '0;
					max_q      <= '0;
					empty_v_q  <= 1'b0;
					vic_v_q    <= 1'b0;
					best_q     <= '0;
				end
				OP_SCAN_EV: begin
					if (nz) begin
						az_q[dep_q] <= 1'b0;
						if (vf > max_q) max_q <= vf;
					end
					if (nz && dep_q != DEP_MAX) begin
						fr_q[dep_q + dep_t'(1)]  <= vf;
						idx_q[dep_q + dep_t'(1)] <= '0;
						az_q[dep_q + dep_t'(1)]  <= 1'b1;
						par_q[dep_q + dep_t'(1)] <= cur_addr;
						dep_q <= dep_q + dep_t'(1);
					end else begin
						if (nz && m > best_q) begin
							vic_v_q    <= 1'b1;
							vic_par_q  <= cur_addr;
							vic_page_q <= path;
							vic_fr_q   <= vf;
							best_q     <= m;
						end
						if (!(&idx_q[dep_q])) idx_q[dep_q] <= idx_q[dep_q] + off_t'(1);
					end
				end
				OP_SCAN_POP: begin
					if (az_q[dep_q] && fr_q[dep_q] != last_q && fr_q[dep_q] != '0) begin
						empty_v_q   <= 1'b1;
						empty_fr_q  <= fr_q[dep_q];
						empty_par_q <= par_q[dep_q];
					end
					if (dep_q != '0) begin
						dep_q <= dep_up;
						if (!(&idx_q[dep_up])) idx_q[dep_up] <= idx_q[dep_up] + off_t'(1);
					end
				end
				OP_PICK: begin
					cnt_q <= '0;
					if (empty_v_q) begin
						unlink_q <= empty_par_q;
						next_q   <= empty_fr_q;
					end else if (max_q < frame_t'(FRAME_COUNT - 1)) begin
						next_q <= max_q + frame_t'(1);
					end else if (vic_v_q) begin
						unlink_q <= vic_par_q;
						next_q   <= vic_fr_q;
						if (evict_q != 2'd3) evict_q <= evict_q + 2'd1;
					end
				end
				OP_CP_WR, OP_CLR_FRAME, OP_RS_WR: cnt_q <= cnt_q + off_t'(1);
				OP_LINK: begin
					last_q <= next_q;
					cnt_q  <= '0;
					if (layer_q == DEP_MAX) frame_q <= next_q;
					else layer_q <= layer_q + dep_t'(1);
				end
				OP_OUT_OK: begin
					ok_q        <= 1'b1;
					rdata_q     <= op_q ? 32'd0 : 32'(phys_rd_q);
					pf_q        <= fault_q;
					ev_q        <= evict_q;
				end
				OP_OUT_FAIL: begin
					ok_q        <= 1'b0;
					rdata_q     <= 32'd0;
					pf_q        <= 1'b1;
					ev_q        <= evict_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign read_data     = rdata_q;
	assign page_fault    = pf_q;
	assign pages_evicted = ev_q;

	a_dep_range: assert property (@(posedge clk) disable iff (!arst_n) dep_q <= DEP_MAX)
		else $error("scan depth beyond last level");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT_OK || cmd.op == OP_OUT_FAIL) |-> out_free)
		else $error("result loaded over a pending beat");
	a_evict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.op == OP_PICK || cmd.op == OP_LOAD) |=> $stable(evict_q))
		else $error("eviction count moved outside pick");

endmodule

// ===== rtl/ptw_ctrl.sv =====
// Controller state machine sequencing walk, scan, fill, restore and access.
`timescale 1ns / 1ps
module ptw_ctrl import ptw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t st,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	logic       evict_q, evict_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			evict_q <= 1'b0;
		end else begin
			state_q <= state_d;
			evict_q <= evict_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		evict_d  = evict_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLR;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				cmd.op  = OP_WALK_RD;
				state_d = S_WALK_EV;
			end
			S_WALK_EV: begin
				cmd.op = OP_WALK_EV;
				priority if (st.walk_zero) state_d = S_SCAN_INIT;
				else if (st.layer_last) state_d = S_ACC;
				else state_d = S_WALK_RD;
			end
			S_SCAN_INIT: begin
				cmd.op  = OP_SCAN_INIT;
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.op  = OP_SCAN_RD;
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.op  = OP_SCAN_EV;
				state_d = (st.ev_push || !st.ev_last) ? S_SCAN_RD : S_SCAN_POP;
			end
			S_SCAN_POP: begin
				cmd.op = OP_SCAN_POP;
				priority if (st.pop_root) state_d = S_PICK;
				else if (st.pop_up_last) state_d = S_SCAN_POP;
				else state_d = S_SCAN_RD;
			end
			S_PICK: begin
				cmd.op = OP_PICK;
				priority if (st.empty_valid) begin
					evict_d = 1'b0;
					state_d = S_UNLINK;
				end else if (st.max_small) begin
					state_d = S_CLR_FRAME;
				end else if (st.victim_valid) begin
					evict_d = 1'b1;
					state_d = S_UNLINK;
				end else begin
					state_d = S_OUT_FAIL;
				end
			end
			S_UNLINK: begin
				cmd.op  = OP_UNLINK;
				state_d = evict_q ? S_CP_RD : S_LINK;
			end
			S_CP_RD: begin
				cmd.op  = OP_CP_RD;
				state_d = S_CP_WR;
			end
			S_CP_WR: begin
				cmd.op  = OP_CP_WR;
				state_d = st.cnt_last ? S_CLR_FRAME : S_CP_RD;
			end
			S_CLR_FRAME: begin
				cmd.op = OP_CLR_FRAME;
				if (st.cnt_last) state_d = S_LINK;
			end
			S_LINK: begin
				cmd.op  = OP_LINK;
				state_d = st.layer_last ? S_RS_RD : S_SCAN_INIT;
			end
			S_RS_RD: begin
				cmd.op  = OP_RS_RD;
				state_d = S_RS_WR;
			end
			S_RS_WR: begin
				cmd.op  = OP_RS_WR;
				state_d = st.cnt_last ? S_ACC : S_RS_RD;
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				state_d = S_OUT_OK;
			end
			S_OUT_OK: begin
				if (st.out_free) begin
					cmd.op  = OP_OUT_OK;
					state_d = S_IDLE;
				end
			end
			S_OUT_FAIL: begin
				if (st.out_free) begin
					cmd.op  = OP_OUT_FAIL;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while an item is in flight");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |=> state_q != S_CLEAR)
		else $error("clearing pass restarted");

endmodule
